// ----- rtl/assert_macros.svh -----
// assertion macros shared by the rtl modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define DHB_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("assertion failed");

// condition must never be seen outside reset
`define DHB_NEVER(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(prop)) \
        else $error("forbidden condition seen");

`endif

// ----- rtl/dhb_pkg.sv -----
// constants, tables and shared types of the b-dot activity core
package dhb_pkg;

    localparam int unsigned CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_IONIC_STRENGTH = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_LOG_LIMIT      = 1'b1;

    localparam logic [15:0] CONST_A     = 16'd33515;
    localparam logic [15:0] CONST_B     = 16'd21548;
    localparam logic [11:0] CONST_BDOT  = 12'd2687;
    localparam logic [31:0] LOG2_10_Q30 = 32'd3566893132;
    localparam logic [29:0] LN2_Q30     = 30'd744261118;
    localparam logic [31:0] ONE_Q24     = 32'h0100_0000;

    localparam int unsigned SQRT_STEPS   = 20;
    localparam int unsigned QUO_W        = 28;
    localparam int unsigned SERIES_TERMS = 12;

    localparam logic signed [19:0] LIMIT_RESET = 20'sd131072;
    localparam logic signed [29:0] LG_FLOOR    = -30'sd524288;

    // floor(x / n) = (x * DIV_MAGIC[n]) >> DIV_SHIFT[n] for any x below 2^31
    localparam logic [31:0] DIV_MAGIC [1:12] = '{
        32'd2147483648, 32'd2147483648, 32'd2863311531, 32'd2147483648,
        32'd3435973837, 32'd2863311531, 32'd2454267027, 32'd2147483648,
        32'd3817748708, 32'd3435973837, 32'd3123612579, 32'd2863311531
    };
    localparam int unsigned DIV_SHIFT [1:12] = '{
        31, 32, 33, 33, 34, 34, 34, 34, 35, 35, 35, 35
    };

    typedef struct packed {
        logic zero;
        logic uflow;
    } t_flags;

    typedef struct packed {
        logic [31:0] coeff;
        logic        sat;
    } t_result;

endpackage

// ----- rtl/debye_huckel_bdot_activity_core.sv -----
// b-dot activity coefficient core: one species per cycle through a deep pipeline
// throughput: one species per cycle; the pipeline advances while the output queue has room
// a write of the ionic strength starts a serial square root, input stalled meanwhile
// reset: synchronous active low; clears valid bits and queue, I to 0, log limit to 2.0
module debye_huckel_bdot_activity_core (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_stall,
    input  logic signed [4:0]                  i_ion_charge,
    input  logic [11:0]                        i_ion_size,
    output logic                               o_valid,
    input  logic                               i_stall,
    output logic [31:0]                        o_activity_coeff,
    output logic                               o_saturated,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [dhb_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [23:0]                        i_cfg_data
);

    localparam int unsigned QW = dhb_pkg::QUO_W;

    logic en;
    logic busy;
    logic accept;
    logic [19:0] sq;
    logic [1:0]  r_cnt;

    // configuration
    logic              cfg_we;
    logic              sqrt_start;
    logic [35:0]       bdi_prod;
    logic [36:0]       bdi_rnd;
    logic [19:0]       r_bdi;
    logic signed [19:0] r_limit;

    assign o_cfg_ready = 1'b1;
    assign cfg_we      = i_cfg_valid && o_cfg_ready;
    assign sqrt_start  = cfg_we && (i_cfg_index == dhb_pkg::REG_IONIC_STRENGTH);
    assign bdi_prod    = dhb_pkg::CONST_BDOT * i_cfg_data;
    assign bdi_rnd     = {1'b0, bdi_prod} + 37'd32768;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bdi   <= '0;
            r_limit <= dhb_pkg::LIMIT_RESET;
        end else if (cfg_we) begin
            case (i_cfg_index)
                dhb_pkg::REG_IONIC_STRENGTH: r_bdi   <= bdi_rnd[35:16];
                dhb_pkg::REG_LOG_LIMIT:      r_limit <= $signed(i_cfg_data[19:0]);
                default: ;
            endcase
        end
    end

    dhb_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (sqrt_start),
        .i_value (i_cfg_data),
        .o_busy  (busy),
        .o_root  (sq)
    );

    assign en      = (r_cnt != 2'd2);
    assign o_stall = !en || busy;
    assign accept  = i_valid && !o_stall;

    // s0: input register
    logic        r_s0_v;
    logic [4:0]  r_s0_z;
    logic [11:0] r_s0_size;

    // s1: z squared, size * sqrt(I)
    logic [4:0]  zabs;
    logic [9:0]  zsq_full;
    logic [31:0] p1;
    logic        r_s1_v;
    logic        r_s1_zero;
    logic [8:0]  r_s1_zsq;
    logic [31:0] r_s1_p1;

    // s2: A z^2, size * B * sqrt(I)
    logic [24:0] az;
    logic [47:0] pb;
    logic        r_s2_v;
    logic        r_s2_zero;
    logic [24:0] r_s2_az;
    logic [46:0] r_s2_pb;

    // s3: numerator, rounded denominator
    logic [44:0] num;
    logic [47:0] pbr;
    logic        r_s3_v;
    logic        r_s3_zero;
    logic [43:0] r_s3_num;
    logic [23:0] r_s3_den;

    assign zabs     = r_s0_z[4] ? (~r_s0_z + 5'd1) : r_s0_z;
    assign zsq_full = zabs * zabs;
    assign p1       = r_s0_size * sq;
    assign az       = r_s1_zsq * dhb_pkg::CONST_A;
    assign pb       = r_s1_p1 * dhb_pkg::CONST_B;
    assign num      = r_s2_az * sq;
    assign pbr      = {1'b0, r_s2_pb} + 48'd8388608;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_v <= 1'b0;
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
            r_s3_v <= 1'b0;
        end else if (en) begin
            r_s0_v <= accept;
            r_s1_v <= r_s0_v;
            r_s2_v <= r_s1_v;
            r_s3_v <= r_s2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s0_z    <= i_ion_charge;
            r_s0_size <= i_ion_size;
            r_s1_zero <= (r_s0_z == 5'd0);
            r_s1_zsq  <= zsq_full[8:0];
            r_s1_p1   <= p1;
            r_s2_zero <= r_s1_zero;
            r_s2_az   <= az;
            r_s2_pb   <= pb[46:0];
            r_s3_zero <= r_s2_zero;
            r_s3_num  <= num[43:0];
            r_s3_den  <= {1'b0, pbr[46:24]} + 24'h01_0000;
        end
    end

    // restoring divider, one quotient bit per stage
    typedef struct packed {
        logic          v;
        logic          zero;
        logic [23:0]   rem;
        logic [QW-1:0] low;
        logic [QW-1:0] quo;
        logic [23:0]   den;
    } t_div_stage;

    logic [43:0] numr;
    t_div_stage  n_div [0:QW];
    t_div_stage  r_div [0:QW];

    assign numr = r_s3_num + {21'b0, r_s3_den[23:1]};

    always_comb begin
        n_div[0].v    = r_s3_v;
        n_div[0].zero = r_s3_zero;
        n_div[0].rem  = {8'h00, numr[43:QW]};
        n_div[0].low  = numr[QW-1:0];
        n_div[0].quo  = '0;
        n_div[0].den  = r_s3_den;
    end

    for (genvar j = 1; j <= QW; j++) begin : g_div
        logic [24:0] rs;
        logic        ge;
        logic [24:0] diff;

        assign rs   = {r_div[j-1].rem, r_div[j-1].low[QW-1]};
        assign ge   = (rs >= {1'b0, r_div[j-1].den});
        assign diff = rs - {1'b0, r_div[j-1].den};

        always_comb begin
            n_div[j]     = r_div[j-1];
            n_div[j].rem = ge ? diff[23:0] : rs[23:0];
            n_div[j].low = {r_div[j-1].low[QW-2:0], 1'b0};
            n_div[j].quo = {r_div[j-1].quo[QW-2:0], ge};
        end
    end

    for (genvar j = 0; j <= QW; j++) begin : g_div_reg
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_div[j].v <= 1'b0;
            end else if (en) begin
                r_div[j] <= n_div[j];
            end
        end
    end

    // e0: log value, clamp, underflow
    logic signed [29:0] lg_full;
    logic signed [29:0] lim30;
    logic signed [29:0] lg_min;
    logic               r_e0_v;
    dhb_pkg::t_flags    r_e0_flags;
    logic signed [19:0] r_e0_lg;

    assign lg_full = $signed({10'b0, r_bdi}) - $signed({2'b0, r_div[QW].quo});
    assign lim30   = {{10{r_limit[19]}}, r_limit};
    assign lg_min  = (lg_full > lim30) ? lim30 : lg_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e0_v <= 1'b0;
        end else if (en) begin
            r_e0_v <= r_div[QW].v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_e0_flags.zero  <= r_div[QW].zero;
            r_e0_flags.uflow <= (lg_min < dhb_pkg::LG_FLOOR);
            r_e0_lg          <= lg_min[19:0];
        end
    end

    logic             f_v;
    dhb_pkg::t_result f_res;

    dhb_exp10 u_exp10 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_e0_v),
        .i_flags (r_e0_flags),
        .i_lg    (r_e0_lg),
        .o_valid (f_v),
        .o_res   (f_res)
    );

    // two-beat output queue decouples the pipeline from the output stall
    logic             push;
    logic             pop;
    dhb_pkg::t_result r_q0;
    dhb_pkg::t_result r_q1;

    assign push = en && f_v;
    assign pop  = (r_cnt != 2'd0) && !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            if (push && r_cnt == 2'd1) begin
                r_q0 <= f_res;
            end else begin
                r_q0 <= r_q1;
            end
            if (push && r_cnt == 2'd2) begin
                r_q1 <= f_res;
            end
        end else if (push) begin
            if (r_cnt == 2'd0) begin
                r_q0 <= f_res;
            end else begin
                r_q1 <= f_res;
            end
        end
    end

    assign o_valid          = (r_cnt != 2'd0);
    assign o_activity_coeff = r_q0.coeff;
    assign o_saturated      = r_q0.sat;

    `include "assert_macros.svh"

    `DHB_ASSERT(a_busy_stalls, i_clk, i_rst_n, busy |-> o_stall)
    `DHB_NEVER(a_queue_overrun, i_clk, i_rst_n, r_cnt == 2'd2 && push)
    `DHB_NEVER(a_queue_count, i_clk, i_rst_n, r_cnt == 2'd3)

endmodule

// ----- rtl/dhb_isqrt.sv -----
// bit-serial square root of the ionic strength, two radicand bits per cycle
module dhb_isqrt (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [23:0] i_value,
    output logic        o_busy,
    output logic [19:0] o_root
);

    logic [39:0] r_src;
    logic [22:0] r_rem;
    logic [19:0] r_root;
    logic [4:0]  r_cnt;
    logic        r_busy;

    logic [24:0] rem_sh;
    logic [24:0] trial;
    logic        ge;

    assign rem_sh = {r_rem, r_src[39:38]};
    assign trial  = {3'b000, r_root, 2'b01};
    assign ge     = (rem_sh >= trial);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
            r_root <= '0;
            r_rem  <= '0;
            r_src  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
            r_root <= '0;
            r_rem  <= '0;
            r_src  <= {i_value, 16'h0000};
        end else if (r_busy) begin
            r_src  <= {r_src[37:0], 2'b00};
            r_root <= {r_root[18:0], ge};
            r_rem  <= ge ? 23'(rem_sh - trial) : rem_sh[22:0];
            if (r_cnt == 5'(dhb_pkg::SQRT_STEPS - 1)) begin
                r_busy <= 1'b0;
                r_cnt  <= '0;
            end else begin
                r_cnt  <= r_cnt + 5'd1;
            end
        end
    end

    assign o_busy = r_busy;
    assign o_root = r_root;

    `include "assert_macros.svh"

    `DHB_ASSERT(a_start_busy, i_clk, i_rst_n, i_start |=> o_busy)
    `DHB_NEVER(a_cnt_range, i_clk, i_rst_n, r_cnt >= 5'(dhb_pkg::SQRT_STEPS))

endmodule

// ----- rtl/dhb_exp10.sv -----
// pipelined 10^x in q8.24: split into 2^ip * e^(f ln2), taylor series, scaling
module dhb_exp10 (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_valid,
    input  dhb_pkg::t_flags      i_flags,
    input  logic signed [19:0]   i_lg,
    output logic                 o_valid,
    output dhb_pkg::t_result     o_res
);

    localparam int unsigned NT = dhb_pkg::SERIES_TERMS;

    typedef struct packed {
        logic            v;
        dhb_pkg::t_flags flags;
        logic [5:0]      ip;
        logic [29:0]     r;
        logic [30:0]     term;
        logic [31:0]     sum;
        logic [29:0]     x;
    } t_ser;

    // split log2 value into integer and fraction
    logic signed [52:0] t_full;
    logic               r_x1_v;
    dhb_pkg::t_flags    r_x1_flags;
    logic [5:0]         r_x1_ip;
    logic [29:0]        r_x1_f30;

    assign t_full = i_lg * $signed({1'b0, dhb_pkg::LOG2_10_Q30});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x1_v <= 1'b0;
        end else if (i_en) begin
            r_x1_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x1_flags <= i_flags;
            r_x1_ip    <= t_full[51:46];
            r_x1_f30   <= t_full[45:16];
        end
    end

    logic [59:0] rp;
    t_ser        n_ser_d [0:NT];
    t_ser        r_ser_d [0:NT];
    t_ser        n_ser_p [1:NT];
    t_ser        r_ser_p [1:NT];

    assign rp = r_x1_f30 * dhb_pkg::LN2_Q30;

    always_comb begin
        n_ser_d[0].v     = r_x1_v;
        n_ser_d[0].flags = r_x1_flags;
        n_ser_d[0].ip    = r_x1_ip;
        n_ser_d[0].r     = rp[59:30];
        n_ser_d[0].term  = 31'h4000_0000;
        n_ser_d[0].sum   = 32'h4000_0000;
        n_ser_d[0].x     = '0;
    end

    for (genvar k = 1; k <= NT; k++) begin : g_term
        logic [60:0] tp;
        logic [61:0] dp;
        logic [61:0] dq;

        // term * r, back to q.30
        assign tp = r_ser_d[k-1].term * r_ser_d[k-1].r;
        always_comb begin
            n_ser_p[k]   = r_ser_d[k-1];
            n_ser_p[k].x = tp[59:30];
        end

        // divide by k through the reciprocal, then accumulate
        assign dp = r_ser_p[k].x * dhb_pkg::DIV_MAGIC[k];
        assign dq = dp >> dhb_pkg::DIV_SHIFT[k];
        always_comb begin
            n_ser_d[k]      = r_ser_p[k];
            n_ser_d[k].term = dq[30:0];
            n_ser_d[k].sum  = r_ser_p[k].sum + {1'b0, dq[30:0]};
        end
    end

    for (genvar k = 0; k <= NT; k++) begin : g_dreg
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_ser_d[k].v <= 1'b0;
            end else if (i_en) begin
                r_ser_d[k] <= n_ser_d[k];
            end
        end
    end

    for (genvar k = 1; k <= NT; k++) begin : g_preg
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_ser_p[k].v <= 1'b0;
            end else if (i_en) begin
                r_ser_p[k] <= n_ser_p[k];
            end
        end
    end

    // scale mantissa by 2^ip into q8.24
    logic signed [5:0] ip;
    logic [39:0]       mm;
    logic [5:0]        sh;
    logic [39:0]       rnd;
    logic [39:0]       g40;
    dhb_pkg::t_result  n_res;
    logic              r_out_v;
    dhb_pkg::t_result  r_out_res;

    assign ip  = $signed(r_ser_d[NT].ip);
    assign mm  = {8'h00, r_ser_d[NT].sum};
    assign sh  = 6'd6 - r_ser_d[NT].ip;
    assign rnd = 40'd1 << (sh - 6'd1);

    always_comb begin
        if (ip >= 6'sd6) begin
            g40 = (ip == 6'sd7) ? {mm[38:0], 1'b0} : mm;
        end else begin
            g40 = (mm + rnd) >> sh;
        end
        if (r_ser_d[NT].flags.zero) begin
            n_res.coeff = dhb_pkg::ONE_Q24;
            n_res.sat   = 1'b0;
        end else if (r_ser_d[NT].flags.uflow) begin
            n_res.coeff = '0;
            n_res.sat   = 1'b0;
        end else if (ip >= 6'sd8 || (|g40[39:32])) begin
            n_res.coeff = '1;
            n_res.sat   = 1'b1;
        end else begin
            n_res.coeff = g40[31:0];
            n_res.sat   = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (i_en) begin
            r_out_v <= r_ser_d[NT].v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_out_res <= n_res;
        end
    end

    assign o_valid = r_out_v;
    assign o_res   = r_out_res;

    `include "assert_macros.svh"

    `DHB_ASSERT(a_sat_full, i_clk, i_rst_n, o_valid && o_res.sat |-> o_res.coeff == 32'hFFFF_FFFF)
    `DHB_ASSERT(a_neutral_one, i_clk, i_rst_n, i_en && r_ser_d[NT].v && r_ser_d[NT].flags.zero |=> o_valid && !o_res.sat && o_res.coeff == dhb_pkg::ONE_Q24)

endmodule

// ----- tb/sv/debye_huckel_bdot_activity_core_test.sv -----
// self-checking testbench of the b-dot activity core with random idling on both sides
module debye_huckel_bdot_activity_core_test;

    typedef struct packed {
        logic [4:0]  charge;
        logic [11:0] size;
    } t_species;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [4:0]  i_ion_charge;
    logic [11:0] i_ion_size;
    logic        o_valid;
    logic        i_stall;
    logic [31:0] o_activity_coeff;
    logic        o_saturated;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [dhb_pkg::CFG_IDX_W-1:0] i_cfg_index;
    logic [23:0] i_cfg_data;

    debye_huckel_bdot_activity_core dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_stall(o_stall),
        .i_ion_charge(i_ion_charge), .i_ion_size(i_ion_size),
        .o_valid(o_valid), .i_stall(i_stall),
        .o_activity_coeff(o_activity_coeff), .o_saturated(o_saturated),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    t_species         species_q[$];
    dhb_pkg::t_result gamma_q[$];
    longint unsigned ionic_q16;
    longint          log_limit_q16;
    int   errors;
    logic species_taken;
    logic gamma_taken;
    int   send_gap;
    int   recv_gap;
    bit   calm;

    always begin
        i_clk = 1'b1; #1;
        i_clk = 1'b0; #1;
    end

    function automatic longint unsigned isqrt(longint unsigned v);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= res + b) begin
                v = v - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    function automatic dhb_pkg::t_result predict_gamma(logic [4:0] z, logic [11:0] a);
        dhb_pkg::t_result res;
        longint unsigned zabs, sq, num, den, den16, term, bdi, u, f30, r, m, g, tm;
        longint          lg, t;
        int              ip, sh;
        res.sat = 1'b0;
        if (z == 5'd0) begin
            res.coeff = dhb_pkg::ONE_Q24;
            return res;
        end
        zabs = z[4] ? 64'd32 - z : z;
        sq = isqrt(ionic_q16 << 16);
        num = 64'(dhb_pkg::CONST_A) * zabs * zabs * sq;
        den = (64'd1 << 40) + 64'(a) * 64'(dhb_pkg::CONST_B) * sq;
        den16 = (den + (64'd1 << 23)) >> 24;
        term = (num + den16 / 2) / den16;
        bdi = (64'(dhb_pkg::CONST_BDOT) * ionic_q16 + (64'd1 << 15)) >> 16;
        lg = longint'(bdi) - longint'(term);
        if (lg > log_limit_q16) lg = log_limit_q16;
        // underflow gives zero without the flag
        if (lg < -(64'sd8 << 16)) begin
            res.coeff = 32'd0;
            return res;
        end
        t = lg * longint'(64'(dhb_pkg::LOG2_10_Q30));
        u = unsigned'(t + (64'sd32 << 46));
        ip = int'(u >> 46) - 32;
        f30 = (u & ((64'd1 << 46) - 1)) >> 16;
        r = (f30 * 64'(dhb_pkg::LN2_Q30)) >> 30;
        m = 64'd1 << 30;
        tm = 64'd1 << 30;
        for (int n = 1; n <= dhb_pkg::SERIES_TERMS; n++) begin
            tm = ((tm * r) >> 30) / n;
            m = m + tm;
        end
        if (ip >= 8) begin
            res.coeff = 32'hFFFF_FFFF;
            res.sat = 1'b1;
            return res;
        end
        if (ip >= 6) begin
            g = m << (ip - 6);
        end else begin
            sh = 6 - ip;
            g = (m + (64'd1 << (sh - 1))) >> sh;
        end
        if (g > 64'hFFFF_FFFF) begin
            res.coeff = 32'hFFFF_FFFF;
            res.sat = 1'b1;
        end else begin
            res.coeff = g[31:0];
        end
        return res;
    endfunction

    // accepted beats on both sides, sampled at the rising edge
    always @(posedge i_clk) begin
        dhb_pkg::t_result got, want;
        species_taken <= i_rst_n && i_valid && !o_stall;
        gamma_taken <= i_rst_n && o_valid && !i_stall;
        if (i_rst_n && i_valid && !o_stall)
            gamma_q.push_back(predict_gamma(i_ion_charge, i_ion_size));
        if (i_rst_n && o_valid && !i_stall) begin
            got.coeff = o_activity_coeff;
            got.sat = o_saturated;
            if (gamma_q.size() == 0) begin
                $display("%0t: result with nothing expected, actual %h/%b",
                         $time, o_activity_coeff, o_saturated);
                errors++;
            end else begin
                want = gamma_q.pop_front();
                if (got.coeff !== want.coeff) begin
                    $display("%0t: activity_coeff expected %h actual %h",
                             $time, want.coeff, got.coeff);
                    errors++;
                end
                if (got.sat !== want.sat) begin
                    $display("%0t: saturated expected %b actual %b",
                             $time, want.sat, got.sat);
                    errors++;
                end
            end
        end
    end

    // species driver
    always @(negedge i_clk) begin
        logic nv;
        nv = i_valid;
        if (i_valid && species_taken) begin
            void'(species_q.pop_front());
            nv = 1'b0;
            send_gap = calm ? 0 : $urandom_range(0, 9);
        end
        if (!nv && i_rst_n) begin
            if (send_gap > 0) begin
                send_gap--;
            end else if (species_q.size() > 0) begin
                i_ion_charge <= species_q[0].charge;
                i_ion_size <= species_q[0].size;
                nv = 1'b1;
            end
        end
        i_valid <= nv;
    end

    // result back-pressure
    always @(negedge i_clk) begin
        if (gamma_taken) recv_gap = calm ? 0 : $urandom_range(0, 9);
        if (recv_gap > 0) begin
            recv_gap--;
            i_stall <= 1'b1;
        end else begin
            i_stall <= 1'b0;
        end
    end

    task automatic write_reg(logic [dhb_pkg::CFG_IDX_W-1:0] idx, logic [23:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == dhb_pkg::REG_IONIC_STRENGTH)
            ionic_q16 = data;
        else
            log_limit_q16 = longint'($signed(data[19:0]));
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        while (species_q.size() > 0 || i_valid || gamma_q.size() > 0)
            @(posedge i_clk);
        // room for the pipeline and a pending square root
        repeat (90) @(posedge i_clk);
    endtask

    task automatic add_species(logic [4:0] z, logic [11:0] a);
        t_species s;
        s.charge = z;
        s.size = a;
        species_q.push_back(s);
    endtask

    task automatic add_random(int count);
        logic [4:0] z;
        for (int k = 0; k < count; k++) begin
            if ($urandom_range(0, 7) == 0)
                z = 5'($urandom);
            else
                z = 5'($urandom_range(0, 16) - 8);
            add_species(z, 12'($urandom));
        end
    endtask

    initial begin
        logic [23:0] ionic_set [8];
        logic [19:0] limit_set [8];
        errors = 0;
        calm = 1'b0;
        send_gap = 0;
        recv_gap = 0;
        ionic_q16 = 0;
        log_limit_q16 = 131072;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_stall = 1'b0;
        i_ion_charge = '0;
        i_ion_size = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        species_taken = 1'b0;
        gamma_taken = 1'b0;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings first: I is zero so every charged species gives 1.0
        add_species(5'd1, 12'd0);
        add_species(5'd0, 12'hFFF);
        drain();

        write_reg(dhb_pkg::REG_IONIC_STRENGTH, 24'h008000);
        foreach (limit_set[k]) ;
        add_species(5'd0, 12'd0);
        add_species(5'd1, 12'd0);
        add_species(5'h1F, 12'hFFF);
        add_species(5'd8, 12'd1024);
        add_species(5'h18, 12'd1024);
        add_species(5'd15, 12'd0);
        add_species(5'h10, 12'hFFF);
        add_species(5'd2, 12'h555);
        add_species(5'h1E, 12'hAAA);
        drain();

        // strong solution: underflow for high charges
        write_reg(dhb_pkg::REG_IONIC_STRENGTH, 24'hFFFFFF);
        write_reg(dhb_pkg::REG_LOG_LIMIT, 24'h07FFFF);
        add_species(5'd1, 12'hFFF);
        add_species(5'd1, 12'd0);
        add_species(5'h10, 12'd0);
        add_species(5'd15, 12'd0);
        add_species(5'd3, 12'd256);
        add_species(5'd0, 12'd0);
        drain();

        // clamp decides: largest limit saturates, smallest gives the floor
        write_reg(dhb_pkg::REG_IONIC_STRENGTH, 24'h000000);
        write_reg(dhb_pkg::REG_LOG_LIMIT, 24'hF80000);
        add_species(5'd1, 12'd0);
        add_species(5'd0, 12'd0);
        drain();
        write_reg(dhb_pkg::REG_IONIC_STRENGTH, 24'h7F0000);
        write_reg(dhb_pkg::REG_LOG_LIMIT, 24'h07FFFF);
        add_species(5'd1, 12'hFFF);
        add_species(5'h1F, 12'hFFF);
        drain();

        ionic_set = '{24'h000000, 24'hFFFFFF, 24'h010000, 24'h001999,
                      24'h000001, 24'h050000, 24'($urandom), 24'($urandom)};
        limit_set = '{20'h20000, 20'h7FFFF, 20'h80000, 20'h00000,
                      20'h30000, 20'hFFFFF, 20'($urandom), 20'($urandom)};
        for (int p = 0; p < 8; p++) begin
            write_reg(dhb_pkg::REG_IONIC_STRENGTH, ionic_set[p]);
            write_reg(dhb_pkg::REG_LOG_LIMIT, {4'($urandom), limit_set[p]});
            calm = (p == 3);
            add_random(90);
            drain();
        end
        calm = 1'b0;

        if (gamma_q.size() != 0) begin
            $display("%0t: %0d results never arrived", $time, gamma_q.size());
            errors++;
        end
        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    initial begin
        #2000000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/dhb_pkg.sv
rtl/dhb_isqrt.sv
rtl/dhb_exp10.sv
rtl/debye_huckel_bdot_activity_core.sv
tb/sv/debye_huckel_bdot_activity_core_test.sv
